FILE: design/fsu_pkg.sv
// Shared constants and controller/datapath interface types for the search unit.
package fsu_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int BOUND_W     = ADDR_W + 1;
    localparam int COUNT_W     = 11;
    localparam int WORD_W      = 32;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef struct packed {
        logic start;      // latch key, open full window, clear hit
        logic rd_mid;     // read table at mid
        logic rd_prev;    // read table at mid - 1
        logic go_left;    // high bound := mid
        logic go_right;   // low bound := mid + 1
        logic mark_hit;   // record hit at mid
        logic publish;    // load output registers
    } cmd_t;

    typedef struct packed {
        logic in_range;   // window not empty
        logic key_lt;     // key < probed entry
        logic key_gt;     // key > probed entry
        logic mid_zero;   // mid is the first entry
        logic prev_diff;  // left neighbor differs from key
    } status_t;

endpackage

FILE: design/fsu_datapath.sv
// Datapath: table memory, search window, comparators and result registers.
module fsu_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [fsu_pkg::ADDR_W-1:0]         entry_index,
    input  logic signed [fsu_pkg::WORD_W-1:0]  entry_value,
    input  logic signed [fsu_pkg::WORD_W-1:0]  search_key,
    input  logic                               cfg_we,
    input  logic [fsu_pkg::COUNT_W-1:0]        cfg_data,
    input  fsu_pkg::cmd_t                      cmd,
    output fsu_pkg::status_t                   status,
    output logic                               found,
    output logic [fsu_pkg::ADDR_W-1:0]         position
);
    import fsu_pkg::*;

    logic signed [WORD_W-1:0] table_mem [TABLE_DEPTH];
    logic signed [WORD_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]        rd_addr;

    logic [COUNT_W-1:0]       entries_in_use_reg;
    logic signed [WORD_W-1:0] key_reg;
    logic [BOUND_W-1:0]       low_reg, low_next;
    logic [BOUND_W-1:0]       high_reg, high_next;
    logic                     hit_reg;
    logic [ADDR_W-1:0]        hit_pos_reg;
    logic                     found_reg;
    logic [ADDR_W-1:0]        position_reg;

    logic [BOUND_W-1:0]       count_sat;
    logic [BOUND_W:0]         mid_sum;
    logic [ADDR_W-1:0]        mid;

    // Counts above the table depth search the whole table.
    assign count_sat = (entries_in_use_reg > COUNT_W'(TABLE_DEPTH))
                       ? BOUND_W'(TABLE_DEPTH) : entries_in_use_reg[BOUND_W-1:0];

    // high_reg is one past the last candidate
    assign mid_sum = {1'b0, low_reg} + {1'b0, high_reg} - (BOUND_W+1)'(1);
    assign mid     = mid_sum[ADDR_W:1];
    assign rd_addr = cmd.rd_prev ? (mid - ADDR_W'(1)) : mid;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[entry_index] <= entry_value;
        end
        if (cmd.rd_mid || cmd.rd_prev)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        if (cmd.start)
        begin
            low_next  = '0;
            high_next = count_sat;
        end
        else if (cmd.go_left)
        begin
            high_next = {1'b0, mid};
        end
        else if (cmd.go_right)
        begin
            low_next = {1'b0, mid} + BOUND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= '0;
            low_reg            <= '0;
            high_reg           <= '0;
            hit_reg            <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                entries_in_use_reg <= cfg_data;
            end
            low_reg  <= low_next;
            high_reg <= high_next;
            if (cmd.start)
            begin
                hit_reg <= 1'b0;
            end
            else if (cmd.mark_hit)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg     <= search_key;
            hit_pos_reg <= '0;
        end
        else if (cmd.mark_hit)
        begin
            hit_pos_reg <= mid;
        end
        if (cmd.publish)
        begin
            found_reg    <= hit_reg;
            position_reg <= hit_pos_reg;
        end
    end

    assign status.in_range  = (low_reg < high_reg);
    assign status.key_lt    = (key_reg < rd_data_reg);
    assign status.key_gt    = (key_reg > rd_data_reg);
    assign status.mid_zero  = (mid == '0);
    assign status.prev_diff = (rd_data_reg != key_reg);

    assign found    = found_reg;
    assign position = position_reg;

endmodule

FILE: design/fsu_ctrl.sv
// Controller: sequences table writes, search iterations and result handoff.
module fsu_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             req_type,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             wr_en,
    output fsu_pkg::cmd_t    cmd,
    input  fsu_pkg::status_t status
);
    import fsu_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_PROBE = 3'd2;
    localparam logic [2:0] S_NEIGH = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign wr_en    = accept && (req_type == REQ_WRITE);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req_type == REQ_SEARCH)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.in_range)
                begin
                    cmd.rd_mid = 1'b1;
                    state_next = S_PROBE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PROBE:
            begin
                priority if (status.key_lt)
                begin
                    cmd.go_left = 1'b1;
                    state_next  = S_CHECK;
                end
                else if (status.key_gt)
                begin
                    cmd.go_right = 1'b1;
                    state_next   = S_CHECK;
                end
                else if (status.mid_zero)
                begin
                    cmd.mark_hit = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_NEIGH;
                end
            end
            S_NEIGH:
            begin
                // equal left neighbor: first occurrence lies further left
                if (status.prev_diff)
                begin
                    cmd.mark_hit = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.go_left = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: design/first_occurrence_search_unit.sv
// Top level of the first-occurrence search unit.
// Holds a 1024-entry table of signed 32-bit values loaded in ascending order by
// write requests (accepted back to back while idle, no result). A search
// request binary-searches the first entries_in_use entries (saturated to 1024)
// and returns found and the lowest matching position. Each probe passes a
// window check and a registered table read, plus a left-neighbor read when an
// equal entry is not at index 0, all through the single read port of the
// table memory. A search over the full table takes at most 11 probes. While an
// earlier result has not been taken the search waits in its done state; after
// that the result sits in an output register while the next request is taken.
module first_occurrence_search_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [fsu_pkg::ADDR_W-1:0]         entry_index,
    input  logic signed [fsu_pkg::WORD_W-1:0]  entry_value,
    input  logic signed [fsu_pkg::WORD_W-1:0]  search_key,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               found,
    output logic [fsu_pkg::ADDR_W-1:0]         position,
    input  logic                               cfg_we,
    input  logic [fsu_pkg::COUNT_W-1:0]        cfg_data
);
    import fsu_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    wr_en;

    fsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .wr_en     (wr_en),
        .cmd       (cmd),
        .status    (status)
    );

    fsu_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .found       (found),
        .position    (position)
    );

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the first-occurrence search unit.
`timescale 1ns / 100ps

module tb_top;
    import fsu_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN       = 40;
    localparam int MAX_COUNT   = (1 << COUNT_W) - 1;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic                     kind;
        logic [ADDR_W-1:0]        index;
        logic signed [WORD_W-1:0] value;
        logic signed [WORD_W-1:0] key;
    } request_t;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] pos;
    } answer_t;

    typedef enum int {FILL_DENSE, FILL_SPARSE, FILL_SHUFFLED} fill_style_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic                     req_type;
    logic [ADDR_W-1:0]        entry_index;
    logic signed [WORD_W-1:0] entry_value;
    logic signed [WORD_W-1:0] search_key;
    logic                     out_valid;
    logic                     out_ready;
    logic                     found;
    logic [ADDR_W-1:0]        position;
    logic                     cfg_we;
    logic [COUNT_W-1:0]       cfg_data;

    // generator side: what has been queued so far
    request_t                 pending_requests[$];
    logic signed [WORD_W-1:0] planned_table [TABLE_DEPTH];
    int                       random_items;
    bit                       bulk_load;
    int                       send_idle_pct;
    int                       recv_stall_pct;

    // checker side: state as of the last accepted request
    logic signed [WORD_W-1:0] table_copy [TABLE_DEPTH];
    int                       count_copy;
    answer_t                  answers_due[$];
    bit                       in_took;
    int                       mismatches;
    int                       writes_seen;
    int                       searches_seen;
    int                       hits_seen;
    int                       settings_used;
    int                       cycles;

    first_occurrence_search_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .position    (position),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, answers_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Binary search for the lowest index holding key; keeps going left while
    // the left neighbor of an equal probe is equal too.
    function automatic answer_t locate_first(input logic signed [WORD_W-1:0] key);
        answer_t a;
        int      lo;
        int      hi;
        int      mid;
        bit      done;
        a.hit = 1'b0;
        a.pos = '0;
        lo = 0;
        hi = ((count_copy > TABLE_DEPTH) ? TABLE_DEPTH : count_copy) - 1;
        done = 1'b0;
        while (!done && lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (key < table_copy[mid])
                hi = mid - 1;
            else if (key > table_copy[mid])
                lo = mid + 1;
            else if (mid == 0 || table_copy[mid-1] != table_copy[mid])
            begin
                a.hit = 1'b1;
                a.pos = ADDR_W'(mid);
                done  = 1'b1;
            end
            else
                hi = mid - 1;
        end
        return a;
    endfunction

    task automatic flag_mismatch(input string what, input answer_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR at %0t: %s: expected found=%0b position=%0d, %s%0b position=%0d",
                     $time, what, want.hit, want.pos, "got found=", found, position);
    endtask

    always @(posedge clk)
    begin : check_results
        answer_t want;
        if (rst_n)
        begin
            if (cfg_we)
                count_copy = int'(cfg_data);
            // results first, so a request taken on this edge cannot be matched
            if (out_valid && out_ready)
            begin
                if (answers_due.size() == 0)
                begin
                    want = '0;
                    flag_mismatch("result with no search outstanding", want);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (found !== want.hit || position !== want.pos)
                        flag_mismatch("wrong result", want);
                end
            end
            in_took = in_valid && in_ready;
            if (in_took)
            begin
                if (req_type == REQ_WRITE)
                begin
                    table_copy[entry_index] = entry_value;
                    writes_seen++;
                end
                else
                begin
                    want = locate_first(search_key);
                    answers_due.push_back(want);
                    searches_seen++;
                    if (want.hit)
                        hits_seen++;
                end
            end
        end
        else
            in_took = 1'b0;
    end

    always @(negedge clk)
    begin : drive_requests
        request_t nxt;
        if (rst_n)
        begin
            if (!in_valid || in_took)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_requests.pop_front();
                    in_valid    <= 1'b1;
                    req_type    <= nxt.kind;
                    entry_index <= nxt.index;
                    entry_value <= nxt.value;
                    search_key  <= nxt.key;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_write(input int idx, input logic signed [WORD_W-1:0] v);
        request_t r;
        r.kind  = REQ_WRITE;
        r.index = ADDR_W'(idx);
        r.value = v;
        r.key   = $urandom;
        pending_requests.push_back(r);
        planned_table[idx] = v;
        if (!bulk_load)
            random_items++;
    endtask

    task automatic queue_search(input logic signed [WORD_W-1:0] k);
        request_t r;
        r.kind  = REQ_SEARCH;
        r.index = $urandom;
        r.value = $urandom;
        r.key   = k;
        pending_requests.push_back(r);
        random_items++;
    endtask

    // Mostly keys present in the searched span, some neighbors of them, some noise.
    function automatic logic signed [WORD_W-1:0] pick_key(input int span);
        logic signed [WORD_W-1:0] k;
        int                       r;
        r = $urandom_range(99);
        if (span == 0 || r < 15)
            k = $urandom;
        else if (r < 22)
            k = r[0] ? WORD_MAX : WORD_MIN;
        else
        begin
            k = planned_table[$urandom_range(span - 1)];
            if (r >= 85)
                k = k - 1;
            else if (r >= 72)
                k = k + 1;
        end
        return k;
    endfunction

    task automatic load_prefix(input int n, input fill_style_t style,
                               input logic signed [WORD_W-1:0] start);
        logic signed [WORD_W-1:0] v;
        v = start;
        for (int i = 0; i < n; i++)
        begin
            if (i != 0)
            begin
                case (style)
                    FILL_DENSE:  v = v + $urandom_range(1);
                    FILL_SPARSE: if ($urandom_range(3) != 0) v = v + $urandom_range(1, 1 << 20);
                    default:     v = $urandom;
                endcase
            end
            queue_write(i, v);
        end
    endtask

    // Wait until every queued request went in and every result came back.
    task automatic settle(input int tail);
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_requests.size() != 0 || in_valid || answers_due.size() != 0);
        repeat (tail) @(posedge clk);
        #1;
    endtask

    task automatic set_count(input int n);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= COUNT_W'(n);
        @(negedge clk);
        cfg_we   <= 1'b0;
        #1;
        settings_used++;
    endtask

    initial
    begin : stimulus
        int                       n;
        int                       span;
        int                       nq;
        int                       phase;
        int                       mode;
        logic signed [WORD_W-1:0] start;
        fill_style_t              style;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        req_type       = REQ_WRITE;
        entry_index    = '0;
        entry_value    = '0;
        search_key     = '0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        bulk_load      = 1'b0;
        count_copy     = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #1;

        // empty table straight out of reset
        queue_search(WORD_MIN);
        queue_search(WORD_MAX);
        settle(DRAIN);

        // small table with a duplicate run at index 0 and one in the middle
        set_count(8);
        queue_write(0, WORD_MIN);
        queue_write(1, WORD_MIN);
        queue_write(2, -1);
        queue_write(3, 0);
        queue_write(4, 0);
        queue_write(5, 0);
        queue_write(6, 7);
        queue_write(7, WORD_MAX);
        queue_search(WORD_MIN);
        queue_search(0);
        queue_search(WORD_MAX);
        queue_search(-1);
        queue_search(7);
        queue_search(1);
        queue_search(-2);
        queue_search(6);

        random_items = 0;
        phase = 0;
        while (random_items < 400)
        begin
            settle(DRAIN);
            mode = phase % 4;
            send_idle_pct  = (mode == 1) ? 81 : (mode == 3) ? 14 : 0;
            recv_stall_pct = (mode == 2) ? 81 : (mode == 3) ? 14 : 0;
            case (phase)
                0: n = TABLE_DEPTH;
                1: n = MAX_COUNT;
                2: n = 0;
                default:
                begin
                    case ($urandom_range(9))
                        0:       n = 1;
                        1:       n = 2;
                        2:       n = TABLE_DEPTH - 1;
                        3:       n = $urandom_range(TABLE_DEPTH + 1, MAX_COUNT);
                        default: n = $urandom_range(3, 48);
                    endcase
                end
            endcase
            set_count(n);
            if (phase == 0)
            begin
                // whole table once, so any later count only reads written entries
                bulk_load = 1'b1;
                load_prefix(TABLE_DEPTH, FILL_SPARSE, WORD_MIN);
                queue_write(TABLE_DEPTH - 1, WORD_MAX);
                bulk_load = 1'b0;
            end
            else if (n > 0 && n <= 64)
            begin
                case ($urandom_range(6))
                    0:       style = FILL_SHUFFLED;
                    1, 2, 3: style = FILL_DENSE;
                    default: style = FILL_SPARSE;
                endcase
                if (style == FILL_DENSE)
                begin
                    start = $urandom_range(40);
                    start = start - 20;
                end
                else
                    start = $signed($urandom) >>> 1;
                load_prefix(n, style, start);
            end
            span = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
            nq = $urandom_range(12, 24);
            for (int q = 0; q < nq; q++)
            begin
                // hold off new requests until the block has drained
                if (q == nq / 2 && (phase == 3 || $urandom_range(3) == 0))
                    settle(0);
                if ($urandom_range(9) == 0)
                    queue_write($urandom_range(TABLE_DEPTH - 1), pick_key(span));
                else
                    queue_search(pick_key(span));
            end
            phase++;
        end

        settle(DRAIN);
        $display("Run covered %0d table writes and %0d searches (%0d hits)",
                 writes_seen, searches_seen, hits_seen);
        $display("across %0d count settings, including empty, full, oversized and %s",
                 settings_used, "unsorted tables under varied stalls.");
        if (mismatches == 0 && answers_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
